/* sv/websocket_frame_deframer_defines.svh */
// Assertion macros for the WebSocket frame deframer.
// Included by the top level only; no other dependencies.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define WSD_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("deframer check failed: condition must never hold");
`define WSD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed: same-cycle implication");
`define WSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed: next-cycle implication");
`else
`define WSD_ASSERT_NEVER(label, clk, rst, expr)
`define WSD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define WSD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* sv/wsd_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by every module of the block.
package wsd_pkg;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4096;
  localparam int unsigned RQ_DEPTH = 4;   // result queue entries, at least 2

  localparam logic [3:0] OPC_MASK_LO = 4'hF;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [15:0] KEY_BYTES = 16'd4;

  localparam logic [3:0] OPC_CONT  = 4'h0;
  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_LEN64 = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [1:0] ACT_DELIVER = 2'd0;
  localparam logic [1:0] ACT_CLOSE   = 2'd1;
  localparam logic [1:0] ACT_PONG    = 2'd2;
  localparam logic [1:0] ACT_IGNORE  = 2'd3;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXTHI = 3'd2,
    PH_EXTLO = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5,
    PH_TAIL  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } wsd_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic [1:0] action;
    logic [3:0] frame_opcode;
    logic       last;
  } wsd_out_t;

  // Up to two results per byte; when only one, it is in slot a.
  typedef struct packed {
    logic     valid_a;
    wsd_out_t res_a;
    logic     valid_b;
    wsd_out_t res_b;
  } wsd_push_t;

endpackage

/* sv/websocket_frame_deframer.sv */
// WebSocket frame deframer, top level. A request accepted into the input register
// is parsed from there, and its results are written to the result queue, which offers them.
// Throughput: one byte per cycle while the result queue has room; a byte that yields a
// payload byte and the frame status pushes both results into the result queue at once.
// Reset (synchronous, rst high) returns the parser to the first header byte,
// empties the queue and sets max_payload to 4096. Uses wsd_pkg, wsd_core, wsd_rq.
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int unsigned DEPTH = RQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  wsd_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output wsd_out_t    out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned LVL_W = $clog2(DEPTH + 1);

  // Input register: holds one request until the queue has room for both
  // results that a single byte can cause.
  logic             in_q_valid;
  wsd_in_t          in_q;
  logic             room;
  logic             proc;
  logic [LVL_W-1:0] level;
  wsd_push_t        core_push;

  assign room     = (level <= LVL_W'(DEPTH - 2));
  assign proc     = in_q_valid && room;
  // Take a new request whenever the held one leaves this cycle or none is held.
  assign in_ready = !in_q_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (proc) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  // Parser: header fields, mask key, unmasking and end-of-buffer status,
  // all in one pass over the held byte.
  wsd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .proc      (proc),
    .item      (in_q),
    .push      (core_push)
  );

  // Result queue: parts the parser from a stalled consumer.
  wsd_rq #(
    .DEPTH (DEPTH)
  ) u_rq (
    .clk       (clk),
    .rst       (rst),
    .push      (core_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .level     (level)
  );

  // Queue never holds more than its depth.
  `WSD_ASSERT_NEVER(a_rq_bound, clk, rst, level > LVL_W'(DEPTH))
  // A second result is only ever the status after a payload byte.
  `WSD_ASSERT_IMPLIES(a_pair_order, clk, rst, core_push.valid_b, core_push.valid_a && core_push.res_a.kind == KIND_DATA && core_push.res_b.kind == KIND_STATUS)
  // Nothing is pushed without a held byte going through the parser.
  `WSD_ASSERT_IMPLIES(a_push_needs_item, clk, rst, !proc, !core_push.valid_a)
  // With no push and no pop the queue level holds.
  `WSD_ASSERT_NEXT(a_level_hold, clk, rst, !core_push.valid_a && !(out_valid && out_ready), $stable(level))

endmodule

/* sv/wsd_rq.sv */
// Result queue of the WebSocket frame deframer: takes up to two results a cycle.
// Depends on wsd_pkg.
module wsd_rq
  import wsd_pkg::*;
#(
  parameter int unsigned DEPTH = RQ_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned LVL_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  wsd_push_t        push,
  output logic             out_valid,
  input  logic             out_ready,
  output wsd_out_t         out_data,
  output logic [LVL_W-1:0] level
);

  wsd_out_t         entries [DEPTH];
  logic [PTR_W-1:0] wptr, wptr_next, rptr, rptr_next;
  logic [PTR_W-1:0] wptr_p1, wptr_p2;
  logic [LVL_W-1:0] level_next;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wptr_p1   = ptr_inc(wptr);
  assign wptr_p2   = ptr_inc(wptr_p1);
  assign out_valid = (level != '0);
  assign out_data  = entries[rptr];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wptr_next  = push.valid_b ? wptr_p2 : (push.valid_a ? wptr_p1 : wptr);
    rptr_next  = pop ? ptr_inc(rptr) : rptr;
    level_next = level + LVL_W'(push.valid_a) + LVL_W'(push.valid_b) - LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      wptr  <= wptr_next;
      rptr  <= rptr_next;
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid_a) begin
      entries[wptr] <= push.res_a;
    end
    if (push.valid_b) begin
      entries[wptr_p1] <= push.res_b;
    end
  end

endmodule

/* sv/wsd_core.sv */
// Frame parser of the WebSocket frame deframer: header, key, unmasking, status.
// Depends on wsd_pkg.
module wsd_core
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic       proc,
  input  wsd_in_t    item,
  output wsd_push_t  push
);

  phase_t      phase, phase_upd, phase_next;
  logic [3:0]  opcode_held, opcode_upd, opcode_held_next;
  logic        mask_on, mask_upd, mask_on_next;
  logic [15:0] length_held, length_upd, length_held_next;
  logic [31:0] key_word, key_upd, key_word_next;
  logic [15:0] byte_position, pos_upd, byte_position_next;
  logic [1:0]  frame_fault, fault_upd, frame_fault_next;
  logic [15:0] max_payload;

  logic [7:0]  key_byte;
  logic [7:0]  plain_byte;
  logic [1:0]  end_status;
  logic [1:0]  end_action;
  wsd_out_t    data_res, status_res;
  logic        data_emit, status_emit;

  // Next state.
  always_comb begin
    logic        go_start;
    logic [15:0] start_len;
    logic [15:0] pos_inc;
    logic [15:0] len_cand;

    phase_upd  = phase;
    opcode_upd = opcode_held;
    mask_upd   = mask_on;
    length_upd = length_held;
    key_upd    = key_word;
    pos_upd    = byte_position;
    fault_upd  = frame_fault;
    go_start   = 1'b0;
    start_len  = length_held;
    pos_inc    = byte_position + 16'd1;
    len_cand   = 16'(item.rx_byte[6:0]);

    case (phase)
      PH_HDR0: begin
        opcode_upd = item.rx_byte[3:0] & OPC_MASK_LO;
        phase_upd  = PH_HDR1;
      end
      PH_HDR1: begin
        mask_upd = item.rx_byte[7];
        if (item.rx_byte[6:0] == LEN_EXT64) begin
          fault_upd = ST_LEN64;
          phase_upd = PH_TAIL;
        end else if (item.rx_byte[6:0] == LEN_EXT16) begin
          phase_upd = PH_EXTHI;
        end else begin
          length_upd = len_cand;
          if (item.rx_byte[7]) begin
            pos_upd   = '0;
            phase_upd = PH_KEY;
          end else begin
            go_start  = 1'b1;
            start_len = len_cand;
          end
        end
      end
      PH_EXTHI: begin
        length_upd = {item.rx_byte, 8'h00};
        phase_upd  = PH_EXTLO;
      end
      PH_EXTLO: begin
        length_upd = {length_held[15:8], item.rx_byte};
        if (mask_on) begin
          pos_upd   = '0;
          phase_upd = PH_KEY;
        end else begin
          go_start  = 1'b1;
          start_len = {length_held[15:8], item.rx_byte};
        end
      end
      PH_KEY: begin
        for (int i = 0; i < 4; i++) begin
          if (byte_position[1:0] == 2'(i)) begin
            key_upd[8*i +: 8] = key_word[8*i +: 8] | item.rx_byte;
          end
        end
        pos_upd = pos_inc;
        if (pos_inc >= KEY_BYTES) begin
          go_start = 1'b1;
        end
      end
      PH_DATA: begin
        pos_upd = pos_inc;
        if (pos_inc >= length_held) begin
          phase_upd = PH_TAIL;
        end
      end
      default: begin
        // tail and unused codes: drop the byte
      end
    endcase

    if (go_start) begin
      pos_upd = '0;
      if (start_len == '0) begin
        fault_upd = ST_RANGE;
        phase_upd = PH_TAIL;
      end else begin
        if (start_len > max_payload) begin
          fault_upd = ST_RANGE;
        end
        phase_upd = PH_DATA;
      end
    end

    // Buffer end returns the frame state to its start.
    if (item.buffer_end) begin
      phase_next         = PH_HDR0;
      opcode_held_next   = '0;
      mask_on_next       = 1'b0;
      length_held_next   = '0;
      key_word_next      = '0;
      byte_position_next = '0;
      frame_fault_next   = ST_OK;
    end else begin
      phase_next         = phase_upd;
      opcode_held_next   = opcode_upd;
      mask_on_next       = mask_upd;
      length_held_next   = length_upd;
      key_word_next      = key_upd;
      byte_position_next = pos_upd;
      frame_fault_next   = fault_upd;
    end
  end

  // Results.
  always_comb begin
    key_byte   = key_word[{byte_position[1:0], 3'b000} +: 8];
    plain_byte = mask_on ? (item.rx_byte ^ key_byte) : item.rx_byte;

    if (fault_upd == ST_LEN64) begin
      end_status = ST_LEN64;
    end else if (phase_upd != PH_TAIL) begin
      end_status = ST_TRUNC;
    end else begin
      end_status = fault_upd;
    end

    end_action = ACT_IGNORE;
    if (end_status == ST_OK) begin
      case (opcode_upd)
        OPC_CONT, OPC_TEXT: end_action = ACT_DELIVER;
        OPC_CLOSE:          end_action = ACT_CLOSE;
        OPC_PING:           end_action = ACT_PONG;
        default:            end_action = ACT_IGNORE;
      endcase
    end

    data_res.kind         = KIND_DATA;
    data_res.data_byte    = plain_byte;
    data_res.status       = ST_OK;
    data_res.action       = ACT_DELIVER;
    data_res.frame_opcode = opcode_held;
    data_res.last         = !item.buffer_end;

    status_res.kind         = KIND_STATUS;
    status_res.data_byte    = 8'h00;
    status_res.status       = end_status;
    status_res.action       = end_action;
    status_res.frame_opcode = opcode_upd;
    status_res.last         = 1'b1;

    data_emit   = proc && (phase == PH_DATA) && (frame_fault == ST_OK);
    status_emit = proc && item.buffer_end;

    push.valid_a = data_emit || status_emit;
    push.res_a   = data_emit ? data_res : status_res;
    push.valid_b = data_emit && status_emit;
    push.res_b   = status_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      opcode_held   <= '0;
      mask_on       <= 1'b0;
      length_held   <= '0;
      key_word      <= '0;
      byte_position <= '0;
      frame_fault   <= ST_OK;
      max_payload   <= MAX_PAYLOAD_RST;
    end else begin
      if (proc) begin
        phase         <= phase_next;
        opcode_held   <= opcode_held_next;
        mask_on       <= mask_on_next;
        length_held   <= length_held_next;
        key_word      <= key_word_next;
        byte_position <= byte_position_next;
        frame_fault   <= frame_fault_next;
      end
      if (cfg_we) begin
        max_payload <= cfg_wdata;
      end
    end
  end

endmodule

/* dv/tb_websocket_frame_deframer.sv */
`timescale 1ns / 100ps
// Self-checking testbench for websocket_frame_deframer: byte stream in, results out.
// Depends on wsd_pkg and the websocket_frame_deframer RTL; holds its own frame predictor.

module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  localparam int unsigned STALL_LIMIT = 4000;  // cycles with no request moving on either side
  localparam int unsigned MAX_REPORTS = 30;
  localparam int unsigned CFG_EVERY   = 80;    // bytes between max_payload changes
  localparam logic [15:0] LIMIT_SWEEP [5] = '{16'd1, 16'd0, 16'hFFFF, 16'd16, 16'd4096};

  // DUT ports; the inputs are driven to known values from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  wsd_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  wsd_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Frame parser state of the predictor, at reset values
  phase_t      m_phase   = PH_HDR0;
  logic [3:0]  m_opcode  = '0;
  logic        m_mask_on = 1'b0;
  logic [15:0] m_length  = '0;
  logic [31:0] m_key     = '0;
  logic [15:0] m_pos     = '0;
  logic [1:0]  m_fault   = ST_OK;
  logic [15:0] m_max     = MAX_PAYLOAD_RST;

  wsd_out_t    deframed_q [$];   // results owed by the DUT, oldest first
  wsd_out_t    due_r;

  int unsigned error_count   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned hold_left     = 0;   // long receiver hold-off, counted down per cycle
  int unsigned sweep_idx     = 0;
  int unsigned last_cfg_at   = 0;

  websocket_frame_deframer i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: one received byte in, zero to two expected results out
  // ---------------------------------------------------------------------------

  // Return the parser to the first header byte after each buffer end.
  function automatic void clear_frame_state();
    m_phase   = PH_HDR0;
    m_opcode  = '0;
    m_mask_on = 1'b0;
    m_length  = '0;
    m_key     = '0;
    m_pos     = '0;
    m_fault   = ST_OK;
  endfunction

  // Length known and key complete: flag empty or oversize frames, then go to payload unless empty.
  function automatic void begin_payload();
    m_pos = '0;
    if (m_length == 16'd0) begin
      m_fault = ST_RANGE;
      m_phase = PH_TAIL;
    end else begin
      if (m_length > m_max) m_fault = ST_RANGE;
      m_phase = PH_DATA;
    end
  endfunction

  // Length field done: collect the mask key first when the mask bit is set.
  function automatic void header_done();
    if (m_mask_on) begin
      m_pos   = '0;
      m_phase = PH_KEY;
    end else begin
      begin_payload();
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic buf_last);
    wsd_out_t   r;
    logic [7:0] key_b;
    logic [1:0] st;
    case (m_phase)
      PH_HDR0: begin
        m_opcode = b[3:0] & OPC_MASK_LO;
        m_phase  = PH_HDR1;
      end
      PH_HDR1: begin
        m_mask_on = b[7];
        if (b[6:0] == LEN_EXT64) begin
          m_fault = ST_LEN64;
          m_phase = PH_TAIL;
        end else if (b[6:0] == LEN_EXT16) begin
          m_phase = PH_EXTHI;
        end else begin
          m_length = {9'd0, b[6:0]};
          header_done();
        end
      end
      PH_EXTHI: begin
        m_length = {b, 8'h00};
        m_phase  = PH_EXTLO;
      end
      PH_EXTLO: begin
        m_length[7:0] = b;
        header_done();
      end
      PH_KEY: begin
        m_key[8 * m_pos[1:0] +: 8] = b;
        m_pos = m_pos + 16'd1;
        if (m_pos >= KEY_BYTES) begin_payload();
      end
      PH_DATA: begin
        key_b = m_key[8 * m_pos[1:0] +: 8];
        if (m_fault == ST_OK) begin
          r              = '0;
          r.kind         = KIND_DATA;
          r.data_byte    = m_mask_on ? (b ^ key_b) : b;
          r.frame_opcode = m_opcode;
          r.last         = !buf_last;
          deframed_q.push_back(r);
        end
        m_pos = m_pos + 16'd1;
        if (m_pos >= m_length) m_phase = PH_TAIL;
      end
      default: ;  // ignore everything after the payload
    endcase

    if (buf_last) begin
      if (m_fault == ST_LEN64) st = ST_LEN64;
      else if (m_phase != PH_TAIL) st = ST_TRUNC;
      else st = m_fault;
      r        = '0;
      r.kind   = KIND_STATUS;
      r.status = st;
      r.action = ACT_IGNORE;
      if (st == ST_OK) begin
        if (m_opcode == OPC_CONT || m_opcode == OPC_TEXT) r.action = ACT_DELIVER;
        else if (m_opcode == OPC_CLOSE) r.action = ACT_CLOSE;
        else if (m_opcode == OPC_PING) r.action = ACT_PONG;
      end
      r.frame_opcode = m_opcode;
      r.last         = 1'b1;
      deframed_q.push_back(r);
      clear_frame_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Sample both handshakes at the edge: compare the result moving out against the oldest
  // expectation, track register writes, then predict for the byte moving in.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (deframed_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_data, 0);
        end else begin
          due_r = deframed_q.pop_front();
          if (out_data.kind !== due_r.kind)
            report_mismatch("kind", out_data.kind, due_r.kind);
          if (out_data.data_byte !== due_r.data_byte)
            report_mismatch("data_byte", out_data.data_byte, due_r.data_byte);
          if (out_data.status !== due_r.status)
            report_mismatch("status", out_data.status, due_r.status);
          if (out_data.action !== due_r.action)
            report_mismatch("action", out_data.action, due_r.action);
          if (out_data.frame_opcode !== due_r.frame_opcode)
            report_mismatch("frame_opcode", out_data.frame_opcode, due_r.frame_opcode);
          if (out_data.last !== due_r.last)
            report_mismatch("last", out_data.last, due_r.last);
        end
      end
      if (cfg_we) m_max = cfg_wdata;
      if (in_valid && in_ready) deframe_byte(in_data.rx_byte, in_data.buffer_end);
    end
  end

  // Receiver: hold off during a requested stretch, otherwise stall at the set rate.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Watchdog: end the run when no request moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("websocket_frame_deframer test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one byte; idle first at the set rate, then hold valid until accepted.
  task automatic send_byte(input logic [7:0] b, input logic buf_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, buffer_end: buf_last};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Send a whole buffer, marking its final byte.
  task automatic send_buffer(input byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // Stop offering and wait until every expected result has arrived, then wait on
  // for a header byte that may still be in flight.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [15:0] v);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Build a frame: header, optional 16-bit length, optional key, payload, tail bytes.
  function automatic byte_q_t make_frame(input logic [3:0] opc, input logic masked,
                                         input int unsigned len, input logic ext16,
                                         input int unsigned tail);
    byte_q_t     q;
    logic [15:0] len16;
    len16 = len[15:0];
    q.push_back({4'($urandom_range(15)), opc});
    if (ext16 || len16 > 16'd125) begin
      q.push_back({masked, LEN_EXT16});
      q.push_back(len16[15:8]);
      q.push_back(len16[7:0]);
    end else begin
      q.push_back({masked, len16[6:0]});
    end
    if (masked) repeat (4) q.push_back(8'($urandom));
    repeat (len) q.push_back(8'($urandom));
    repeat (tail) q.push_back(8'($urandom));
    return q;
  endfunction

  // Mostly well-formed frames with random content; some truncated, some with a
  // 64-bit length, some plain noise.
  task automatic send_random_frame();
    byte_q_t     q;
    logic [3:0]  opc;
    int unsigned len;
    int unsigned cut;
    logic        ext16;
    int unsigned pick;
    case ($urandom_range(5))
      0: opc = OPC_CONT;
      1: opc = OPC_TEXT;
      2: opc = OPC_CLOSE;
      3: opc = OPC_PING;
      default: opc = 4'($urandom);
    endcase
    pick = $urandom_range(99);
    if (pick < 55) begin
      len   = $urandom_range(12);
      ext16 = ($urandom_range(9) == 0);
    end else if (pick < 75) begin
      len   = $urandom_range(125, 13);
      ext16 = 1'b0;
    end else if (pick < 97) begin
      len   = $urandom_range(300);
      ext16 = 1'b1;
    end else begin
      len   = $urandom_range(600);
      ext16 = 1'b1;
    end
    q = make_frame(opc, 1'($urandom), len, ext16,
                   ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0);
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_buffer(q);
    end else if (pick < 85) begin
      // cut the buffer short anywhere, down to one byte
      if (q.size() > 1) begin
        cut = $urandom_range(q.size() - 1, 1);
        while (q.size() > cut) void'(q.pop_back());
      end
      send_buffer(q);
    end else if (pick < 93) begin
      // 64-bit length, then junk up to the buffer end
      while (q.size() > 1) void'(q.pop_back());
      q.push_back({1'($urandom), LEN_EXT64});
      repeat ($urandom_range(10)) q.push_back(8'($urandom));
      send_buffer(q);
    end else begin
      q.delete();
      repeat ($urandom_range(8, 1)) q.push_back(8'($urandom));
      send_buffer(q);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short hand-built buffers at the reset limit.
  task automatic test_directed();
    byte_q_t q;
    q = '{8'h81};                                        // one-byte buffer
    send_buffer(q);
    q = '{8'h81, 8'h01, 8'hFF};                          // text, one byte, unmasked
    send_buffer(q);
    q = '{8'h88, 8'h82, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 8'hFF};  // masked close
    send_buffer(q);
    q = '{8'h89, 8'h00};                                 // ping with empty payload
    send_buffer(q);
    q = '{8'h0A, 8'h01, 8'h00, 8'hFF};                   // unknown opcode, trailing byte
    send_buffer(q);
    q = '{8'h82, 8'hFF, 8'h00};                          // 64-bit length
    send_buffer(q);
    q = '{8'h80, 8'h7E, 8'h00, 8'h03, 8'hAA, 8'hBB};     // 16-bit length, short payload
    send_buffer(q);
    q = '{8'h01, 8'h85, 8'h11};                          // ends inside the mask key
    send_buffer(q);
  endtask

  // Length exactly at and one above the reset max_payload, cut short after a few
  // payload bytes (payload flows at the limit, none above it), and a short 16-bit length.
  task automatic test_reset_limit();
    byte_q_t q;
    q = make_frame(OPC_TEXT, 1'b0, 4096, 1'b1, 0);
    while (q.size() > 12) void'(q.pop_back());
    send_buffer(q);
    q = make_frame(OPC_CONT, 1'b1, 4097, 1'b1, 0);
    while (q.size() > 14) void'(q.pop_back());
    send_buffer(q);
    send_buffer(make_frame(OPC_PING, 1'b1, 5, 1'b1, 1));
  endtask

  // Random frames, stepping max_payload through its extremes and random values.
  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if (bytes_sent - last_cfg_at >= CFG_EVERY) begin
        if (sweep_idx < 5) write_max_payload(LIMIT_SWEEP[sweep_idx]);
        else if ($urandom_range(3) == 0) write_max_payload(16'($urandom));
        else write_max_payload(16'($urandom_range(40, 2)));
        sweep_idx++;
        last_cfg_at = bytes_sent;
      end
      send_random_frame();
    end
  endtask

  // Hold the receiver off while a long frame streams in, so the result queue fills
  // and the input stalls; then pause the sender until everything has drained.
  task automatic test_backpressure();
    write_max_payload(16'hFFFF);
    hold_left = 300;
    send_buffer(make_frame(OPC_TEXT, 1'b1, 60, 1'b0, 0));
    send_buffer(make_frame(OPC_CLOSE, 1'b0, 3, 1'b0, 0));
    wait_drain();
    send_buffer(make_frame(OPC_PING, 1'b1, 7, 1'b0, 0));
  endtask

  // Longest length the 16-bit field allows, at the largest limit, cut short after
  // a few payload bytes.
  task automatic test_longest_frame();
    byte_q_t q;
    write_max_payload(16'hFFFF);
    q = make_frame(OPC_TEXT, 1'b1, 65535, 1'b1, 0);
    while (q.size() > 20) void'(q.pop_back());
    send_buffer(q);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 20;
    rcv_stall_pct = 49;
    test_directed();
    test_reset_limit();
    test_random_traffic(250);

    send_idle_pct = 49;
    rcv_stall_pct = 20;
    test_random_traffic(250);
    test_backpressure();

    send_idle_pct = 0;
    rcv_stall_pct = 0;
    test_random_traffic(250);
    test_longest_frame();

    wait_drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("websocket_frame_deframer test passed");
    end else begin
      $display("websocket_frame_deframer test failed");
    end
    $finish;
  end

endmodule
